@@ design/neighbor_discovery_table_assert.svh @@
// Assertion macros shared by the neighbour table checker.
// No dependencies; include by bare file name.
`ifndef NEIGHBOR_DISCOVERY_TABLE_ASSERT_SVH
`define NEIGHBOR_DISCOVERY_TABLE_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, quiet in reset
`define NDT_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ndt check failed");

// next-cycle implication
`define NDT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ndt check failed");

`endif

@@ design/ndt_pkg.sv @@
// Package for the neighbour discovery table: sizes, request codes, payload types.
// No dependencies.
package ndt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic signed [15:0] NO_NEIGHBOR_RSSI = -16'sd1000;

   localparam logic [2:0] REQ_CLEAR  = 3'd0;
   localparam logic [2:0] REQ_BEACON = 3'd1;
   localparam logic [2:0] REQ_COUNT  = 3'd2;
   localparam logic [2:0] REQ_READ   = 3'd3;
   localparam logic [2:0] REQ_BEST   = 3'd4;

   localparam logic ST_DONE     = 1'b0;
   localparam logic ST_REJECTED = 1'b1;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [31:0]        node_id;
      logic signed [15:0] rssi_remote;
      logic signed [15:0] rssi_local;
      logic [5:0]         entry_index;
      logic signed [15:0] rssi_limit;
   } ndt_req_type;

   typedef struct packed {
      logic               status;
      logic [6:0]         table_count;
      logic [5:0]         read_index;
      logic [31:0]        read_id;
      logic signed [15:0] read_rssi_remote;
      logic signed [15:0] read_rssi_local;
      logic [31:0]        best_id;
      logic signed [15:0] best_rssi;
   } ndt_rsp_type;

   typedef struct packed {
      logic [31:0]        node_id;
      logic signed [15:0] rssi_remote;
      logic signed [15:0] rssi_local;
   } ndt_entry_type;

endpackage

@@ design/neighbor_discovery_table.sv @@
// Top level of the neighbour discovery table; uses ndt_pkg.
// Path to result: clear, count query and rejects go straight from idle to finish; an entry
//   read passes through the read wait; beacon record and best search first scan the N filled entries.
// Throughput: one request at a time, taken once the previous result sits in the output
//   register; a scan of the full table holds off the next request until the scan ends.
// Reset (synchronous, active high) zeroes the fill count and the output valid; entries left as is.
module neighbor_discovery_table
   import ndt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ndt_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ndt_rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,   // waiting for a request
      ST_SCAN   = 4'b0010,   // walking filled entries (beacon lookup or best search)
      ST_RDWAIT = 4'b0100,   // waits on the registered memory read for an entry read
      ST_FINISH = 4'b1000    // result ready, waits for a free output register
   } ndt_state_type;

   // entry storage: one synchronous memory, registered read
   ndt_entry_type entry_mem_ff [TABLE_DEPTH];
   ndt_entry_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   ndt_entry_type    wr_data;

   ndt_state_type    state_ff, state_in;
   ndt_req_type      req_ff, req_in;        // request under work
   logic [CNT_W-1:0] cnt_ff, cnt_in;        // fill count
   logic [CNT_W-1:0] iss_ff, iss_in;        // next slot to read in a scan
   logic             dv_ff, dv_in;          // rd_data_ff holds a scanned slot
   logic [IDX_W-1:0] di_ff, di_in;          // slot that rd_data_ff came from
   logic signed [15:0] best_ff, best_in;
   logic [31:0]      best_id_ff, best_id_in;
   ndt_rsp_type      res_ff, res_in;        // result being built
   logic             rsp_valid_ff, rsp_valid_in;
   ndt_rsp_type      rsp_data_ff, rsp_data_in;

   logic               issue_more;
   logic               hit;
   logic signed [15:0] cur_min;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign issue_more = (iss_ff < cnt_ff);
   assign hit        = dv_ff && (rd_data_ff.node_id == req_ff.node_id);
   assign cur_min    = (rd_data_ff.rssi_remote < rd_data_ff.rssi_local) ?
                       rd_data_ff.rssi_remote : rd_data_ff.rssi_local;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      iss_in       = iss_ff;
      dv_in        = 1'b0;
      di_in        = di_ff;
      best_in      = best_ff;
      best_id_in   = best_id_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = iss_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = di_ff;
      wr_data      = '{node_id: req_ff.node_id, rssi_remote: req_ff.rssi_remote,
                       rssi_local: req_ff.rssi_local};

      // output register drains independently of the engine
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // address the requested slot now so an entry read has data next cycle
            rd_addr = IDX_W'(req_data.entry_index);
            if (req_valid) begin
               req_in     = req_data;
               iss_in     = '0;
               best_in    = NO_NEIGHBOR_RSSI;
               best_id_in = '0;
               res_in     = '0;
               case (req_data.req_type)
                  REQ_CLEAR: begin
                     // stale entries stay behind the fill count and are never read
                     cnt_in   = '0;
                     state_in = ST_FINISH;
                  end
                  REQ_BEACON, REQ_BEST: begin
                     state_in = ST_SCAN;
                  end
                  REQ_COUNT: begin
                     state_in = ST_FINISH;
                  end
                  REQ_READ: begin
                     if (CNT_W'(req_data.entry_index) < cnt_ff) begin
                        state_in = ST_RDWAIT;
                     end else begin
                        res_in.status = ST_REJECTED;
                        state_in      = ST_FINISH;
                     end
                  end
                  default: begin
                     res_in.status = ST_REJECTED;
                     state_in      = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // issue one read per cycle; compare the slot read last cycle
            dv_in = issue_more;
            di_in = iss_ff[IDX_W-1:0];
            if (issue_more) begin
               iss_in = iss_ff + 1'b1;
            end
            if (req_ff.req_type == REQ_BEACON) begin
               if (hit) begin
                  // known node: refresh strengths in place, drop the read in flight
                  wr_en    = 1'b1;
                  wr_addr  = di_ff;
                  dv_in    = 1'b0;
                  state_in = ST_FINISH;
               end else if (!issue_more && !dv_ff) begin
                  if (cnt_ff < CNT_W'(TABLE_DEPTH)) begin
                     wr_en   = 1'b1;
                     wr_addr = cnt_ff[IDX_W-1:0];
                     cnt_in  = cnt_ff + 1'b1;
                  end else begin
                     res_in.status = ST_REJECTED;
                  end
                  state_in = ST_FINISH;
               end
            end else begin
               // strict > keeps the first of equal strengths
               if (dv_ff && (cur_min > best_ff) && (cur_min < req_ff.rssi_limit)) begin
                  best_in    = cur_min;
                  best_id_in = rd_data_ff.node_id;
               end
               if (!issue_more && !dv_ff) begin
                  res_in.best_id   = best_id_ff;
                  res_in.best_rssi = best_ff;
                  state_in         = ST_FINISH;
               end
            end
         end

         ST_RDWAIT: begin
            res_in.read_index       = req_ff.entry_index;
            res_in.read_id          = rd_data_ff.node_id;
            res_in.read_rssi_remote = rd_data_ff.rssi_remote;
            res_in.read_rssi_local  = rd_data_ff.rssi_local;
            state_in                = ST_FINISH;
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in             = res_ff;
               rsp_data_in.table_count = 7'(cnt_ff);
               rsp_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      iss_ff      <= iss_in;
      di_ff       <= di_in;
      best_ff     <= best_in;
      best_id_ff  <= best_id_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

endmodule

@@ design/ndt_checker.sv @@
// Port-level checker for the neighbour discovery table, bound to the top level.
// Uses ndt_pkg and neighbor_discovery_table_assert.svh.
`include "neighbor_discovery_table_assert.svh"

module ndt_checker
   import ndt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input ndt_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input ndt_rsp_type rsp_data
);

   // requests taken but not yet answered
   logic [1:0] pend_ff, pend_in;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 1'b1;
      end else if (!req_acc && rsp_acc) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `NDT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `NDT_ASSERT_NOW(a_no_phantom, rsp_valid, pend_ff != 2'd0)
   `NDT_ASSERT_NOW(a_bounded, req_ready, pend_ff < 2'd2)
   `NDT_ASSERT_NOW(a_count_range, rsp_valid, rsp_data.table_count <= 7'(TABLE_DEPTH))
   `NDT_ASSERT_NOW(a_reject_clean, rsp_valid && (rsp_data.status == ST_REJECTED),
      (rsp_data.read_id == '0) && (rsp_data.best_id == '0) && (rsp_data.best_rssi == '0))

endmodule

bind neighbor_discovery_table ndt_checker u_ndt_checker (.*);

@@ tb/neighbor_discovery_table_tb.sv @@
// Self-checking testbench for the neighbour discovery table: random bursts of requests
// against a behavioural mirror of the table, checked result by result.
// Depends on ndt_pkg and neighbor_discovery_table.
`timescale 1ns / 100ps

module neighbor_discovery_table_tb;
   import ndt_pkg::*;

   // request codes the block does not define; it must answer them with a reject
   localparam logic [2:0] REQ_SPARE_5 = 3'd5;
   localparam logic [2:0] REQ_SPARE_6 = 3'd6;
   localparam logic [2:0] REQ_SPARE_7 = 3'd7;

   localparam int ITEM_TARGET     = 1650;
   localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no handshake on either side
   localparam int DRAIN_CYCLES    = 100;   // run-on after the last result, before the end check
   localparam int HOLD_AFTER      = 300;   // results taken before the long hold-off
   localparam int HOLD_CYCLES     = 600;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_pattern_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ndt_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ndt_rsp_type rsp_data;

   ndt_req_type   pending_requests [$];
   ndt_rsp_type   predicted_results [$];
   ndt_entry_type neighbour_mirror [TABLE_DEPTH];
   int            mirror_fill   = 0;
   int            mismatch_count = 0;

   neighbor_discovery_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Mirror of the table: applies one request and returns the answer the
   // block should give. Lookup takes the first matching filled slot.
   // ------------------------------------------------------------------
   function automatic ndt_rsp_type neighbour_answer(ndt_req_type rq);
      ndt_rsp_type        ans;
      int                 slot;
      int                 i;
      logic signed [15:0] rem;
      logic signed [15:0] loc;
      logic signed [15:0] weakest;
      logic signed [15:0] best;
      logic signed [15:0] ceiling;
      ans = '0;
      case (rq.req_type)
         REQ_CLEAR: begin
            for (i = 0; i < TABLE_DEPTH; i++) neighbour_mirror[i] = '0;
            mirror_fill = 0;
         end
         REQ_BEACON: begin
            // walk downwards so the lowest matching slot is the one kept
            slot = mirror_fill;
            for (i = mirror_fill - 1; i >= 0; i--)
               if (neighbour_mirror[i].node_id == rq.node_id) slot = i;
            if (slot < TABLE_DEPTH) begin
               neighbour_mirror[slot].node_id     = rq.node_id;
               neighbour_mirror[slot].rssi_remote = rq.rssi_remote;
               neighbour_mirror[slot].rssi_local  = rq.rssi_local;
               if (slot == mirror_fill) mirror_fill++;
            end else begin
               ans.status = ST_REJECTED;  // new id, table full
            end
         end
         REQ_COUNT: begin
         end
         REQ_READ: begin
            if (int'(rq.entry_index) < mirror_fill) begin
               ans.read_index       = rq.entry_index;
               ans.read_id          = neighbour_mirror[rq.entry_index].node_id;
               ans.read_rssi_remote = neighbour_mirror[rq.entry_index].rssi_remote;
               ans.read_rssi_local  = neighbour_mirror[rq.entry_index].rssi_local;
            end else begin
               ans.status = ST_REJECTED;
            end
         end
         REQ_BEST: begin
            // strict compare: ties keep the earlier slot, -1000 or less never wins
            best    = NO_NEIGHBOR_RSSI;
            ceiling = rq.rssi_limit;
            for (i = 0; i < mirror_fill; i++) begin
               rem     = neighbour_mirror[i].rssi_remote;
               loc     = neighbour_mirror[i].rssi_local;
               weakest = (rem < loc) ? rem : loc;
               if (weakest > best && weakest < ceiling) begin
                  best        = weakest;
                  ans.best_id = neighbour_mirror[i].node_id;
               end
            end
            ans.best_rssi = best;
         end
         default: begin
            ans.status = ST_REJECTED;
         end
      endcase
      ans.table_count = 7'(mirror_fill);
      return ans;
   endfunction

   function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Request builders. Every field not used by the request type is random,
   // so the block is also shown to ignore it.
   // ------------------------------------------------------------------
   function automatic ndt_req_type any_req(logic [2:0] kind);
      logic [95:0] raw;
      ndt_req_type rq;
      raw         = {$urandom, $urandom, $urandom};
      rq          = raw[$bits(ndt_req_type)-1:0];
      rq.req_type = kind;
      return rq;
   endfunction

   function automatic ndt_req_type beacon(logic [31:0] id, logic signed [15:0] rem,
                                          logic signed [15:0] loc);
      ndt_req_type rq;
      rq             = any_req(REQ_BEACON);
      rq.node_id     = id;
      rq.rssi_remote = rem;
      rq.rssi_local  = loc;
      return rq;
   endfunction

   function automatic ndt_req_type read_at(logic [5:0] idx);
      ndt_req_type rq;
      rq             = any_req(REQ_READ);
      rq.entry_index = idx;
      return rq;
   endfunction

   function automatic ndt_req_type best_below(logic signed [15:0] ceiling);
      ndt_req_type rq;
      rq            = any_req(REQ_BEST);
      rq.rssi_limit = ceiling;
      return rq;
   endfunction

   // strengths: often a narrow band so ties and qualifying entries are common
   function automatic logic signed [15:0] rand_strength();
      int v;
      case ($urandom_range(0, 4))
         0:       v = int'($urandom);
         1:       v = $urandom_range(0, 1) ? 32767 : -32768;
         2:       v = -1003 + int'($urandom_range(0, 6));
         default: v = -120 + int'($urandom_range(0, 140));
      endcase
      return v[15:0];
   endfunction

   function automatic logic signed [15:0] rand_ceiling();
      int v;
      case ($urandom_range(0, 4))
         0:       v = int'($urandom);
         1:       v = $urandom_range(0, 1) ? 32767 : -32768;
         2:       v = -1000 + int'($urandom_range(0, 2));
         default: v = -100 + int'($urandom_range(0, 130));
      endcase
      return v[15:0];
   endfunction

   function automatic logic [5:0] rand_index();
      return $urandom_range(0, 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 15));
   endfunction

   function automatic ndt_req_type rand_query();
      case ($urandom_range(0, 2))
         0:       return read_at(rand_index());
         1:       return best_below(rand_ceiling());
         default: return any_req(REQ_COUNT);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request list and end of run
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [31:0] id_pool [12];
      logic [31:0] fresh_ids [$];
      logic [31:0] id;
      int          n;
      int          j;
      int          sel;

      // empty table
      pending_requests.push_back(any_req(REQ_COUNT));
      pending_requests.push_back(read_at(6'd0));
      pending_requests.push_back(best_below(16'sd32767));
      // id and strength extremes; min of -32768 never qualifies
      pending_requests.push_back(beacon(32'h0000_0000, 16'sd32767, -16'sd32768));
      pending_requests.push_back(beacon(32'hFFFF_FFFF, -16'sd32768, 16'sd32767));
      // two entries with equal min strength: the earlier one must win
      pending_requests.push_back(beacon(32'h1234_5678, 16'sd100, 16'sd50));
      pending_requests.push_back(beacon(32'hA5A5_5A5A, 16'sd50, 16'sd120));
      pending_requests.push_back(best_below(16'sd32767));
      pending_requests.push_back(best_below(16'sd50));   // nothing qualifies
      // min of exactly -1000 never beats the starting value
      pending_requests.push_back(beacon(32'h0000_0100, -16'sd1000, -16'sd999));
      pending_requests.push_back(best_below(-16'sd999));
      // known id: strengths overwritten in place, count unchanged
      pending_requests.push_back(beacon(32'h1234_5678, 16'sd40, 16'sd60));
      pending_requests.push_back(best_below(16'sd32767));
      pending_requests.push_back(read_at(6'd2));
      pending_requests.push_back(read_at(6'd5));         // index equal to count
      pending_requests.push_back(read_at(6'd63));
      pending_requests.push_back(beacon(32'hFFFF_FFFF, 16'sd7, 16'sd9));
      pending_requests.push_back(read_at(6'd1));
      pending_requests.push_back(any_req(REQ_SPARE_5));
      pending_requests.push_back(any_req(REQ_SPARE_6));
      pending_requests.push_back(any_req(REQ_SPARE_7));
      pending_requests.push_back(any_req(REQ_CLEAR));
      pending_requests.push_back(any_req(REQ_COUNT));
      pending_requests.push_back(read_at(6'd0));
      pending_requests.push_back(best_below(16'sd32767));

      foreach (id_pool[k]) id_pool[k] = $urandom;
      id_pool[0] = 32'h0000_0000;
      id_pool[1] = 32'hFFFF_FFFF;

      while (pending_requests.size() < ITEM_TARGET) begin
         sel = $urandom_range(0, 9);
         if (sel < 2) begin
            // fill from empty, mostly new ids, long enough to overflow the table often
            pending_requests.push_back(any_req(REQ_CLEAR));
            fresh_ids.delete();
            n = $urandom_range(80, 110);
            for (j = 0; j < n; j++) begin
               sel = $urandom_range(0, 9);
               if (sel < 7) begin
                  id = $urandom;
                  fresh_ids.push_back(id);
                  pending_requests.push_back(beacon(id, rand_strength(), rand_strength()));
               end else if (sel == 7 && fresh_ids.size() > 0) begin
                  id = fresh_ids[$urandom_range(0, fresh_ids.size() - 1)];
                  pending_requests.push_back(beacon(id, rand_strength(), rand_strength()));
               end else begin
                  pending_requests.push_back(rand_query());
               end
            end
         end else if (sel < 8) begin
            // small id pool: repeated updates, reads and searches over a few entries
            n = $urandom_range(20, 40);
            for (j = 0; j < n; j++) begin
               sel = $urandom_range(0, 19);
               if (sel == 0)
                  pending_requests.push_back(any_req(REQ_CLEAR));
               else if (sel <= 8)
                  pending_requests.push_back(beacon(id_pool[$urandom_range(0, 11)],
                                                    rand_strength(), rand_strength()));
               else if (sel <= 12)
                  pending_requests.push_back(read_at(rand_index()));
               else if (sel <= 17)
                  pending_requests.push_back(best_below(rand_ceiling()));
               else if (sel == 18)
                  pending_requests.push_back(any_req(REQ_COUNT));
               else
                  pending_requests.push_back(any_req(3'($urandom_range(5, 7))));
            end
         end else begin
            // noise: any code, all fields random
            n = $urandom_range(1, 4);
            for (j = 0; j < n; j++)
               pending_requests.push_back(any_req(3'($urandom_range(0, 7))));
         end
      end

      @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || predicted_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && predicted_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         if (predicted_results.size() != 0)
            $display("%0t: %0d results never arrived", $time, predicted_results.size());
         $display("simulation failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Sender: bursts of back-to-back requests, random gaps between bursts.
   // Valid holds with a steady payload until the request is taken.
   // ------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: stall pattern switches every so often; once, a long hold-off
   // so the block backs up and stops taking requests.
   // ------------------------------------------------------------------
   rx_pattern_type rx_pattern = RX_OPEN;
   int             pattern_left = 0;
   int             hold_left    = 0;
   bit             hold_done    = 1'b0;
   int             taken        = 0;
   int             rx_tick      = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_tick++;
         if (rsp_valid && rsp_ready) taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               rx_pattern   = rx_pattern_type'($urandom_range(0, 3));
               pattern_left = $urandom_range(16, 200);
            end else begin
               pattern_left--;
            end
            case (rx_pattern)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= (rx_tick[2:0] != 3'd0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: a taken request is applied to the mirror first, then a taken
   // result is checked against the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      ndt_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            predicted_results.push_back(neighbour_answer(req_data));
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               $display("%0t: result with nothing outstanding, expected none actual %h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = predicted_results.pop_front();
               compare_field("status", want.status, rsp_data.status);
               compare_field("table_count", want.table_count, rsp_data.table_count);
               compare_field("read_index", want.read_index, rsp_data.read_index);
               compare_field("read_id", want.read_id, rsp_data.read_id);
               compare_field("read_rssi_remote", want.read_rssi_remote,
                             rsp_data.read_rssi_remote);
               compare_field("read_rssi_local", want.read_rssi_local,
                             rsp_data.read_rssi_local);
               compare_field("best_id", want.best_id, rsp_data.best_id);
               compare_field("best_rssi", want.best_rssi, rsp_data.best_rssi);
            end
         end
      end
   end

   // watchdog: no handshake on either side for too long means a hang
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

endmodule
